// ===== hdl/positional_insert_remove_list_macros.svh =====
// Assertion macros shared by the list checker.
`ifndef POSITIONAL_INSERT_REMOVE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_REMOVE_LIST_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define PIRL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define PIRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pirl_pkg.sv =====
// Types and codes shared by the positional insert/remove list.
package pirl_pkg;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BADPOS = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;
  localparam logic [1:0] STATUS_FULL   = 2'd3;

  // A dump never emits more items than this.
  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic [1:0]         func;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [3:0]         element_index;
    logic [4:0]         count;
    logic               last;
  } out_item_t;

endpackage

// ===== hdl/positional_insert_remove_list.sv =====
// Top level of the positional insert/remove list.
// An ordered list of signed 32-bit values lives in one synchronous memory of LIST_DEPTH
// words with one write port and one read port (read data registered).
// One item is worked on at a time. Errors (bad position, empty, full, unused code) answer
// at once, and the next item can then be taken. After an insert at position p the block
// moves the entries from the end down to p one place up and then writes the new value
// (ST_MOVE, then ST_PUT); after a remove it moves the entries behind p one place down
// (ST_MOVE), since the memory moves one entry per cycle by read and write-back. A dump
// emits min(n, 16) items, one per cycle while the output is taken; the first entry is
// read from memory and registered before it appears. The result item of an insert or remove
// is ready in the cycle after the item is taken. The memory needs no clearing after reset.
module positional_insert_remove_list #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pirl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pirl_pkg::out_item_t out_data
);
  import pirl_pkg::*;

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOVE = 4'b0010,
    ST_PUT  = 4'b0100,
    ST_DUMP = 4'b1000
  } fsm_t;

  fsm_t            state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ins_r, ins_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic [AW-1:0]   src_r, src_nxt;
  logic [AW-1:0]   dst_r, dst_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [31:0]     val_r, val_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            rdv_r, rdv_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic [31:0]     mem [LIST_DEPTH];
  logic [31:0]     rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [31:0]     mem_wd;
  logic [AW-1:0]   mem_ra;

  logic            out_free;
  logic            accept;
  logic            dump_last;

  // Handshake: new items only when idle and the output register can take a result.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The dump ends at the last entry or at the result limit.
  assign dump_last = (int'(idx_r) == int'(cnt_r) - 1) || (int'(idx_r) == MAX_RESULTS - 1);

  // Next-state logic for the sequencer, the memory port and the output register.
  always_comb begin
    out_item_t resp;
    logic      resp_en;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ins_nxt       = ins_r;
    rem_nxt       = rem_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    pend_nxt      = pend_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    rdv_nxt       = rdv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = dst_r;
    mem_wd        = rd_data_r;
    mem_ra        = src_r;
    resp_en       = 1'b0;
    resp.status        = STATUS_OK;
    resp.element       = '0;
    resp.element_index = '0;
    resp.count         = 5'(cnt_r);
    resp.last          = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          resp_en = 1'b1;
          unique case (in_data.func)
            FUNC_INSERT: begin
              if (int'(in_data.position) > int'(cnt_r)) begin
                resp.status = STATUS_BADPOS;
              end else if (int'(cnt_r) == LIST_DEPTH) begin
                resp.status = STATUS_FULL;
              end else begin
                cnt_nxt    = cnt_r + 1'b1;
                resp.count = 5'(cnt_r + 1'b1);
                ins_nxt    = 1'b1;
                rem_nxt    = cnt_r - CW'(in_data.position);
                src_nxt    = AW'(cnt_r - 1'b1);
                pend_nxt   = 1'b0;
                pos_nxt    = AW'(in_data.position);
                val_nxt    = in_data.value;
                state_nxt  = ST_MOVE;
              end
            end
            FUNC_REMOVE: begin
              if (cnt_r == '0) begin
                resp.status = STATUS_EMPTY;
              end else if (int'(in_data.position) >= int'(cnt_r)) begin
                resp.status = STATUS_BADPOS;
              end else begin
                cnt_nxt    = cnt_r - 1'b1;
                resp.count = 5'(cnt_r - 1'b1);
                ins_nxt    = 1'b0;
                rem_nxt    = cnt_r - CW'(in_data.position) - 1'b1;
                src_nxt    = AW'(in_data.position) + AW'(1);
                pend_nxt   = 1'b0;
                state_nxt  = ST_MOVE;
              end
            end
            FUNC_DUMP: begin
              if (cnt_r == '0) begin
                resp.status = STATUS_EMPTY;
              end else begin
                resp_en   = 1'b0;
                idx_nxt   = '0;
                rdv_nxt   = 1'b0;
                state_nxt = ST_DUMP;
              end
            end
            default: begin
              resp.status = STATUS_BADPOS;
            end
          endcase
        end
      end

      // Copy one entry per cycle: read the source now, write it back one place over next cycle.
      ST_MOVE: begin
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (rem_r != '0) begin
          mem_ra   = src_r;
          src_nxt  = ins_r ? src_r - 1'b1 : src_r + 1'b1;
          dst_nxt  = ins_r ? src_r + 1'b1 : src_r - 1'b1;
          rem_nxt  = rem_r - 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ins_r ? ST_PUT : ST_IDLE;
        end
      end

      // Write the new value into the gap left by the move.
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = pos_r;
        mem_wd    = val_r;
        state_nxt = ST_IDLE;
      end

      // Stream entries out; the read address holds while the output register is full.
      ST_DUMP: begin
        mem_ra = idx_r;
        if (rdv_r && out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = STATUS_OK;
          out_data_nxt.element       = rd_data_r;
          out_data_nxt.element_index = 4'(idx_r);
          out_data_nxt.count         = 5'(cnt_r);
          out_data_nxt.last          = dump_last;
          if (dump_last) begin
            rdv_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            mem_ra  = idx_r + 1'b1;
          end
        end else if (!rdv_r) begin
          rdv_nxt = 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (resp_en) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = resp;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers and the output item.
  always_ff @(posedge clk) begin
    ins_r      <= ins_nxt;
    rem_r      <= rem_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // Element memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

endmodule

// ===== hdl/pirl_checker.sv =====
// Port checker for the positional insert/remove list, with its bind statement.
`include "positional_insert_remove_list_macros.svh"

module pirl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input pirl_pkg::out_item_t out_data
);
  import pirl_pkg::*;

  // A result item held back by the consumer does not change.
  `PIRL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")

  // Any failing status is a lone, final item.
  `PIRL_ASSERT_SAME(a_err_last, clk, rst_n, out_valid && (out_data.status != STATUS_OK), out_data.last, "error result not marked last")

  // Items that are not the last of a dump carry an ok status.
  `PIRL_ASSERT_SAME(a_mid_ok, clk, rst_n, out_valid && !out_data.last, out_data.status == STATUS_OK, "dump entry with error status")

  // A dump streams without gaps: the next entry follows with the next index and same count.
  `PIRL_ASSERT_NEXT(a_dump_seq, clk, rst_n, out_valid && out_ready && !out_data.last, out_valid && (out_data.element_index == $past(out_data.element_index) + 4'd1) && (out_data.count == $past(out_data.count)), "dump sequence broken")

endmodule

bind positional_insert_remove_list pirl_checker u_pirl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/positional_insert_remove_list_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the positional insert/remove list, with its own list predictor.
module positional_insert_remove_list_test;
  import pirl_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int TAIL_ITEMS = 15;
  // The func field has one code that names no operation.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    in_item_t item;
    bit       pause;
  } stim_entry_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Stimulus waiting to be sent and list results still owed by the block.
  stim_entry_t pending_items[$];
  out_item_t   expected_results[$];

  // Predicted list contents.
  logic signed [31:0] list_vals[LIST_DEPTH];
  int unsigned        list_len = 0;

  // Running length of the list as seen by the stimulus generator.
  int unsigned gen_len = 0;

  int  send_gap = 0;
  int  hold_left = 0;
  int  phase_left = 0;
  bit  allow_idle = 1'b0;
  bit  stim_done = 1'b0;
  int  cycle_count = 0;
  int  mismatch_count = 0;
  int  results_checked = 0;
  int  n_inserts = 0;
  int  n_removes = 0;
  int  n_dumps = 0;
  int  n_unused = 0;
  int  n_full = 0;
  int  deepest = 0;

  positional_insert_remove_list #(
    .LIST_DEPTH(LIST_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock and a single reset at the start of the run.
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Idling is allowed in some stretches only, and never near the end of the stimulus.
  function automatic bit idle_ok();
    return allow_idle && (pending_items.size() >= TAIL_ITEMS);
  endfunction

  always @(posedge clk) begin
    if (phase_left == 0) begin
      allow_idle <= ($urandom_range(2) != 0);
      phase_left <= $urandom_range(80, 20);
    end else begin
      phase_left <= phase_left - 1;
    end
  end

  // Works out the result items that one accepted item causes, and updates the list.
  function automatic void predict_results(input in_item_t req);
    out_item_t   res;
    int unsigned shown;
    int unsigned i;
    res = '0;
    res.last = 1'b1;
    case (req.func)
      FUNC_INSERT: begin
        n_inserts++;
        if (req.position > list_len) begin
          res.status = STATUS_BADPOS;
        end else if (list_len >= LIST_DEPTH) begin
          res.status = STATUS_FULL;
          n_full++;
        end else begin
          for (i = list_len; i > req.position; i--) begin
            list_vals[i] = list_vals[i - 1];
          end
          list_vals[req.position] = req.value;
          list_len++;
          res.status = STATUS_OK;
        end
        res.count = 5'(list_len);
        expected_results.push_back(res);
      end
      FUNC_REMOVE: begin
        n_removes++;
        if (list_len == 0) begin
          res.status = STATUS_EMPTY;
        end else if (req.position >= list_len) begin
          res.status = STATUS_BADPOS;
        end else begin
          for (i = req.position; i + 1 < list_len; i++) begin
            list_vals[i] = list_vals[i + 1];
          end
          list_len--;
          res.status = STATUS_OK;
        end
        res.count = 5'(list_len);
        expected_results.push_back(res);
      end
      FUNC_DUMP: begin
        n_dumps++;
        if (list_len == 0) begin
          res.status = STATUS_EMPTY;
          expected_results.push_back(res);
        end else begin
          shown = (list_len > MAX_RESULTS) ? MAX_RESULTS : list_len;
          for (i = 0; i < shown; i++) begin
            res.status = STATUS_OK;
            res.element = list_vals[i];
            res.element_index = 4'(i);
            res.count = 5'(list_len);
            res.last = (i + 1 == shown);
            expected_results.push_back(res);
          end
        end
      end
      default: begin
        n_unused++;
        res.status = STATUS_BADPOS;
        res.count = 5'(list_len);
        expected_results.push_back(res);
      end
    endcase
    if (list_len > deepest) deepest = list_len;
  endfunction

  // Compares one result item from the block with the oldest one owed.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] result item with none owed: status %0d element %0d index %0d count %0d last %0b",
                 $realtime, got.status, got.element, got.element_index, got.count, got.last);
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (got.status !== want.status || got.element !== want.element ||
          got.element_index !== want.element_index || got.count !== want.count ||
          got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("[%0t] mismatch: expected status %0d element %0d index %0d count %0d last %0b",
                   $realtime, want.status, want.element, want.element_index, want.count,
                   want.last);
          $display("[%0t]           actual   status %0d element %0d index %0d count %0d last %0b",
                   $realtime, got.status, got.element, got.element_index, got.count, got.last);
        end
      end
    end
  endtask

  // Monitor: predicts on each accepted item, then checks each accepted result item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_results(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  // Driver: sends queued items, holding each until it is taken, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap <= 0;
      stim_done <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // Item not yet taken: keep it on the port unchanged.
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_items.size() == 0) begin
      in_valid <= 1'b0;
      stim_done <= 1'b1;
    end else if (pending_items[0].pause) begin
      // Hold off until the block has delivered everything it owes.
      in_valid <= 1'b0;
      if (!in_valid && expected_results.size() == 0) void'(pending_items.pop_front());
    end else begin
      in_valid <= 1'b1;
      in_data <= pending_items[0].item;
      void'(pending_items.pop_front());
      if (idle_ok() && $urandom_range(3) == 0) send_gap <= $urandom_range(13, 1);
    end
  end

  // Receiver: takes result items, with random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (idle_ok() && $urandom_range(5) == 0) begin
      out_ready <= 1'b0;
      hold_left <= $urandom_range(12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Stimulus helpers; the generator keeps its own idea of the list length.
  function automatic void queue_op(input logic [1:0] func, input int unsigned pos,
                                   input logic [31:0] val);
    stim_entry_t entry;
    entry.item.func = func;
    entry.item.position = 5'(pos);
    entry.item.value = val;
    entry.pause = 1'b0;
    pending_items.push_back(entry);
    if (func == FUNC_INSERT && pos <= gen_len && gen_len < LIST_DEPTH) gen_len++;
    if (func == FUNC_REMOVE && gen_len > 0 && pos < gen_len) gen_len--;
  endfunction

  function automatic void queue_pause();
    stim_entry_t entry;
    entry.item = '0;
    entry.pause = 1'b1;
    pending_items.push_back(entry);
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: directed corner cases, a fill to capacity, then a random mix.
  initial begin
    int k;
    int pick;
    int unsigned aim;

    // Empty list: dump, removes and out-of-range inserts.
    queue_op(FUNC_DUMP, 0, 0);
    queue_op(FUNC_REMOVE, 0, 0);
    queue_op(FUNC_REMOVE, 31, 32'hFFFF_FFFF);
    queue_op(FUNC_INSERT, 1, 32'h1234_5678);
    queue_op(FUNC_INSERT, 31, 32'hFFFF_FFFF);
    // Build a short list at the front, at the end and in the middle.
    queue_op(FUNC_INSERT, 0, 32'h7FFF_FFFF);
    queue_op(FUNC_INSERT, 0, 32'h8000_0000);
    queue_op(FUNC_INSERT, 2, 32'hFFFF_FFFF);
    queue_op(FUNC_INSERT, 1, 32'h0000_0000);
    queue_op(FUNC_DUMP, 31, 32'h5A5A_A5A5);
    // Removes at the count and far beyond it, and the unused code.
    queue_op(FUNC_REMOVE, 4, 0);
    queue_op(FUNC_REMOVE, 31, 0);
    queue_op(FUNC_UNUSED, 31, 32'hFFFF_FFFF);
    queue_op(FUNC_UNUSED, 0, 0);
    // Remove the last entry, then empty the list from the front.
    queue_op(FUNC_REMOVE, 3, 0);
    queue_op(FUNC_REMOVE, 0, 0);
    queue_op(FUNC_REMOVE, 0, 0);
    queue_op(FUNC_REMOVE, 0, 32'hFFFF_FFFF);
    queue_op(FUNC_DUMP, 0, 0);
    queue_pause();

    // Fill to capacity at random positions, then push against the full list.
    while (gen_len < LIST_DEPTH) queue_op(FUNC_INSERT, $urandom_range(gen_len), random_value());
    queue_op(FUNC_INSERT, LIST_DEPTH, random_value());
    queue_op(FUNC_INSERT, 0, random_value());
    queue_op(FUNC_INSERT, LIST_DEPTH + 1, random_value());
    queue_op(FUNC_DUMP, 0, 0);
    queue_op(FUNC_REMOVE, LIST_DEPTH, 0);
    queue_op(FUNC_REMOVE, LIST_DEPTH - 1, 0);
    queue_op(FUNC_INSERT, LIST_DEPTH - 1, random_value());
    queue_op(FUNC_DUMP, 0, 0);
    queue_pause();

    // Random mix that wanders between random fill levels, with some noise.
    aim = $urandom_range(LIST_DEPTH);
    for (k = 0; k < 85; k++) begin
      pick = $urandom_range(99);
      if (gen_len == aim) aim = $urandom_range(LIST_DEPTH);
      if (pick < 8)
        queue_op(FUNC_DUMP, $urandom_range(31), random_value());
      else if (pick < 13)
        queue_op(FUNC_UNUSED, $urandom_range(31), random_value());
      else if (pick < 25)
        queue_op(pick[0] ? FUNC_INSERT : FUNC_REMOVE, $urandom_range(31), random_value());
      else if (gen_len < aim || gen_len == 0)
        queue_op(FUNC_INSERT, $urandom_range(gen_len), random_value());
      else
        queue_op(FUNC_REMOVE, $urandom_range(gen_len - 1), random_value());
      if (k == 40) queue_pause();
    end
    queue_op(FUNC_DUMP, 0, 0);
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[%0t] run did not finish within %0d cycles", $realtime, CYCLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // End of run: wait for all owed results, let the block settle, then report.
  initial begin
    @(posedge rst_n);
    while (!(stim_done && expected_results.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d inserts, %0d removes, %0d dumps and %0d unused codes.",
             n_inserts, n_removes, n_dumps, n_unused);
    $display("Checked %0d result items; %0d inserts refused as full; deepest list %0d; %0d mismatches.",
             results_checked, n_full, deepest, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
